[design/sms_pkg.sv]
// Package for the SUSI master message serializer.
// Holds the transaction structs, item mode codes, CSR indexes, reset values and state type.
// No dependencies.
`default_nettype none

package sms_pkg;

   localparam int unsigned MSG_BITS  = 16;
   localparam int unsigned BIT_IDX_W = 4;
   localparam int unsigned CFG_W     = 8;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MESSAGES_PER_SYNC = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_GAP_TICKS    = 1'd1;

   localparam logic [CFG_W-1:0] MESSAGES_PER_SYNC_RESET = 8'd8;
   localparam logic [CFG_W-1:0] SYNC_GAP_TICKS_RESET    = 8'd1;

   localparam logic [BIT_IDX_W-1:0] LAST_BIT = 4'd15;

   typedef struct packed {
      logic       mode;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic buffer_full;
      logic clock_line;
      logic data_line;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

`default_nettype wire

[design/sms_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module sms_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 8
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/susi_master_message_serializer.sv]
// Top level of the SUSI master message serializer.
// Depends on sms_pkg and sms_ram.
//
// An enqueue transaction or a tick that falls in a sync gap or on a low phase is handled without a stall;
// its result strobes on rsp_valid in the next cycle and busy stays low. A tick on a high phase
// reads the current slot from the slot memory, whose read is registered, so it passes through
// ST_READ: busy is high for one cycle and the result strobes in the cycle after. Each result is
// shown for exactly one cycle and is not held; the receiver cannot stall. Configuration writes
// are always ready and take effect at once; issue them only while no transaction is in flight.
`default_nettype none

module susi_master_message_serializer #(
   parameter int unsigned SLOT_COUNT = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire sms_pkg::req_type                  req_payload,
   output logic                                   rsp_valid,
   output sms_pkg::rsp_type                       rsp_payload,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sms_pkg::CFG_W-1:0]         csr_data
);

   localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   sms_pkg::state_type state_ff, state_in;
   logic [SLOT_COUNT-1:0] pending_ff, pending_in;
   logic phase_high_ff, phase_high_in;
   logic [sms_pkg::BIT_IDX_W-1:0] bit_index_ff, bit_index_in;
   logic [SLOT_W-1:0] slot_index_ff, slot_index_in;
   logic [7:0] since_sync_ff, since_sync_in;
   logic [7:0] gap_left_ff, gap_left_in;
   logic clock_level_ff, clock_level_in;
   logic data_level_ff, data_level_in;
   logic [sms_pkg::CFG_W-1:0] msgs_per_sync_ff, msgs_per_sync_in;
   logic [sms_pkg::CFG_W-1:0] gap_ticks_ff, gap_ticks_in;
   logic rsp_valid_ff, rsp_valid_in;
   sms_pkg::rsp_type rsp_ff, rsp_in;

   logic accept;
   logic high_read;
   logic free_found;
   logic [SLOT_W-1:0] free_idx;
   logic [7:0] since_next;
   logic ram_wr_en;
   logic ram_rd_en;
   logic [sms_pkg::MSG_BITS-1:0] ram_rd_data;

   assign accept    = start && !busy;
   assign high_read = accept && (req_payload.mode == sms_pkg::MODE_TICK) &&
                      (gap_left_ff == 8'd0) && phase_high_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign ram_wr_en   = accept && (req_payload.mode == sms_pkg::MODE_ENQUEUE) && free_found;

   sms_ram #(
      .WIDTH(sms_pkg::MSG_BITS),
      .DEPTH(SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx),
      .wr_data ({req_payload.second_byte, req_payload.first_byte}),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_index_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!pending_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sms_pkg::ST_IDLE: begin
            if (high_read) begin
               state_in = sms_pkg::ST_READ;
            end
         end
         sms_pkg::ST_READ: state_in = sms_pkg::ST_IDLE;
         default:          state_in = sms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = 1'b0;
      ram_rd_en = 1'b0;
      case (state_ff)
         sms_pkg::ST_IDLE: ram_rd_en = high_read;
         sms_pkg::ST_READ: busy = 1'b1;
         default:          busy = 1'b0;
      endcase
   end

   always_comb begin
      pending_in     = pending_ff;
      phase_high_in  = phase_high_ff;
      bit_index_in   = bit_index_ff;
      slot_index_in  = slot_index_ff;
      since_sync_in  = since_sync_ff;
      gap_left_in    = gap_left_ff;
      clock_level_in = clock_level_ff;
      data_level_in  = data_level_ff;
      msgs_per_sync_in = msgs_per_sync_ff;
      gap_ticks_in     = gap_ticks_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      since_next     = since_sync_ff + 8'd1;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            sms_pkg::CSR_MESSAGES_PER_SYNC: msgs_per_sync_in = csr_data;
            sms_pkg::CSR_SYNC_GAP_TICKS:    gap_ticks_in     = csr_data;
            default: ;
         endcase
      end

      if (state_ff == sms_pkg::ST_READ) begin
         data_level_in  = pending_ff[slot_index_ff] ? ram_rd_data[bit_index_ff] : 1'b0;
         clock_level_in = 1'b1;
         phase_high_in  = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_in         = '{accepted: 1'b0, buffer_full: 1'b0,
                            clock_line: 1'b1, data_line: data_level_in};
      end else if (accept) begin
         if (req_payload.mode == sms_pkg::MODE_ENQUEUE) begin
            if (free_found) begin
               pending_in[free_idx] = 1'b1;
            end
         end else if (gap_left_ff != 8'd0) begin
            gap_left_in = gap_left_ff - 8'd1;
         end else if (!phase_high_ff) begin
            bit_index_in = bit_index_ff + 1'b1;
            if (bit_index_ff == sms_pkg::LAST_BIT) begin
               pending_in[slot_index_ff] = 1'b0;
               slot_index_in = (slot_index_ff == LAST_SLOT) ? '0 : slot_index_ff + 1'b1;
               since_sync_in = since_next;
               if (since_next >= msgs_per_sync_ff) begin
                  since_sync_in = 8'd0;
                  gap_left_in   = gap_ticks_ff;
               end
            end
            clock_level_in = 1'b0;
            phase_high_in  = 1'b1;
         end
         rsp_valid_in = !high_read;
         rsp_in       = '{accepted: (req_payload.mode == sms_pkg::MODE_ENQUEUE) && free_found,
                          buffer_full: (req_payload.mode == sms_pkg::MODE_ENQUEUE) &&
                                       !free_found,
                          clock_line: clock_level_in, data_line: data_level_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= sms_pkg::ST_IDLE;
         pending_ff       <= '0;
         phase_high_ff    <= 1'b1;
         bit_index_ff     <= '0;
         slot_index_ff    <= '0;
         since_sync_ff    <= '0;
         gap_left_ff      <= '0;
         clock_level_ff   <= 1'b0;
         data_level_ff    <= 1'b0;
         msgs_per_sync_ff <= sms_pkg::MESSAGES_PER_SYNC_RESET;
         gap_ticks_ff     <= sms_pkg::SYNC_GAP_TICKS_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pending_ff       <= pending_in;
         phase_high_ff    <= phase_high_in;
         bit_index_ff     <= bit_index_in;
         slot_index_ff    <= slot_index_in;
         since_sync_ff    <= since_sync_in;
         gap_left_ff      <= gap_left_in;
         clock_level_ff   <= clock_level_in;
         data_level_ff    <= data_level_in;
         msgs_per_sync_ff <= msgs_per_sync_in;
         gap_ticks_ff     <= gap_ticks_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   a_phase_vs_clock: assert property (@(posedge clock) disable iff (reset)
      phase_high_ff != clock_level_ff)
      else $error("phase and clock level out of step");

   a_read_follows_tick: assert property (@(posedge clock) disable iff (reset)
      state_ff == sms_pkg::ST_READ |-> $past(high_read))
      else $error("slot read without a high-phase tick");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(accept) && !$past(high_read)) ||
                       $past(state_ff == sms_pkg::ST_READ))
      else $error("response without a transaction");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.accepted && rsp_ff.buffer_full))
      else $error("accepted and buffer full together");

   a_enqueue_sets_pending: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> pending_ff[$past(free_idx)])
      else $error("enqueued slot not marked pending");

endmodule

`default_nettype wire

[sim/sms_line_checker.sv]
// Checker for the SUSI master message serializer: models the slot buffer and the
// serial lines, and compares every response transaction with its prediction.
// Depends on sms_pkg.

module sms_line_checker #(
   parameter int unsigned SLOT_COUNT = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire sms_pkg::req_type              req_payload,
   input  wire logic                          rsp_valid,
   input  wire sms_pkg::rsp_type              rsp_payload,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [sms_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sms_pkg::CFG_W-1:0]     csr_data,
   output int unsigned                        fail_count,
   output int unsigned                        outstanding,
   output int unsigned                        refusals,
   output int unsigned                        gap_ticks
);

   logic [sms_pkg::MSG_BITS-1:0]  slot_word [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]         slot_full;
   logic                          phase_high;
   logic [sms_pkg::BIT_IDX_W-1:0] bit_idx;
   int unsigned                   slot_idx;
   logic [7:0]                    since_sync;
   logic [7:0]                    gap_left;
   logic                          clk_level;
   logic                          data_level;
   logic [sms_pkg::CFG_W-1:0]     msgs_per_sync;
   logic [sms_pkg::CFG_W-1:0]     gap_len;

   sms_pkg::rsp_type expected_levels[$];

   function automatic sms_pkg::rsp_type advance_bus(input sms_pkg::req_type item);
      sms_pkg::rsp_type r;
      int               free_slot;
      r = '0;
      if (item.mode == sms_pkg::MODE_ENQUEUE) begin
         free_slot = -1;
         for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!slot_full[i]) free_slot = i;
         end
         if (free_slot < 0) begin
            r.buffer_full = 1'b1;
            refusals++;
         end else begin
            slot_word[free_slot] = {item.second_byte, item.first_byte};
            slot_full[free_slot] = 1'b1;
            r.accepted = 1'b1;
         end
      end else if (gap_left != 0) begin
         gap_left--;
         gap_ticks++;
      end else if (phase_high) begin
         data_level = slot_full[slot_idx] ? slot_word[slot_idx][bit_idx] : 1'b0;
         clk_level  = 1'b1;
         phase_high = 1'b0;
      end else begin
         if (bit_idx == sms_pkg::LAST_BIT) begin
            slot_full[slot_idx] = 1'b0;
            slot_idx = (slot_idx + 1) % SLOT_COUNT;
            since_sync++;
            if (since_sync >= msgs_per_sync) begin
               since_sync = '0;
               gap_left   = gap_len;
            end
         end
         bit_idx++;
         clk_level  = 1'b0;
         phase_high = 1'b1;
      end
      r.clock_line = clk_level;
      r.data_line  = data_level;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      sms_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) slot_word[i] = '0;
         slot_full     = '0;
         phase_high    = 1'b1;
         bit_idx       = '0;
         slot_idx      = 0;
         since_sync    = '0;
         gap_left      = '0;
         clk_level     = 1'b0;
         data_level    = 1'b0;
         msgs_per_sync = sms_pkg::MESSAGES_PER_SYNC_RESET;
         gap_len       = sms_pkg::SYNC_GAP_TICKS_RESET;
         expected_levels.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: response with nothing expected, got %b", $time, rsp_payload);
               fail_count++;
            end else begin
               want = expected_levels.pop_front();
               check_field("accepted", want.accepted, rsp_payload.accepted);
               check_field("buffer_full", want.buffer_full, rsp_payload.buffer_full);
               check_field("clock_line", want.clock_line, rsp_payload.clock_line);
               check_field("data_line", want.data_line, rsp_payload.data_line);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sms_pkg::CSR_MESSAGES_PER_SYNC: msgs_per_sync = csr_data;
               sms_pkg::CSR_SYNC_GAP_TICKS:    gap_len = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) expected_levels.push_back(advance_bus(req_payload));
      end
      outstanding <= expected_levels.size();
   end

endmodule

[sim/susi_master_message_serializer_test.sv]
// Testbench top for the SUSI master message serializer: drives enqueue and tick
// transactions and register writes, and gives the verdict.
// Depends on sms_pkg, sms_line_checker and the serializer RTL.

module susi_master_message_serializer_test;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASES      = 6;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   sms_pkg::req_type              req_payload;
   logic                          rsp_valid;
   sms_pkg::rsp_type              rsp_payload;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [sms_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sms_pkg::CFG_W-1:0]     csr_data;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned refusals;
   int unsigned gap_ticks;
   int unsigned cycles;
   int unsigned enqueues;
   int unsigned ticks;
   int unsigned burst_left;
   bit          no_idle;

   logic [sms_pkg::CFG_W-1:0] phase_msgs  [PHASES] = '{8'd8, 8'd1, 8'd0, 8'd255, 8'd0, 8'd2};
   logic [sms_pkg::CFG_W-1:0] phase_gap   [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd1, 8'd3, 8'd2};
   int unsigned               phase_items [PHASES] = '{375, 350, 300, 300, 250, 250};
   int unsigned               phase_tick  [PHASES] = '{70, 97, 60, 98, 85, 50};
   bit                        phase_quiet [PHASES] = '{0, 0, 1, 0, 1, 0};

   susi_master_message_serializer dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   sms_line_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .refusals    (refusals),
      .gap_ticks   (gap_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic sms_pkg::req_type make_item(input logic mode, input logic [7:0] lo,
                                                  input logic [7:0] hi);
      sms_pkg::req_type item;
      item.mode        = mode;
      item.first_byte  = lo;
      item.second_byte = hi;
      return item;
   endfunction

   task automatic send(input sms_pkg::req_type item);
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      if (item.mode == sms_pkg::MODE_TICK) ticks++;
      else enqueues++;
   endtask

   // insert a random gap between bursts, unless no_idle is set
   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         if (!no_idle) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [sms_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sms_pkg::CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      enqueues    = 0;
      ticks       = 0;
      burst_left  = 0;
      no_idle     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // free slot 0 goes out as zeros, then gets filled mid-message
      repeat (3) send(make_item(sms_pkg::MODE_TICK, 8'h00, 8'h00));
      send(make_item(sms_pkg::MODE_ENQUEUE, 8'hFF, 8'h00));
      send(make_item(sms_pkg::MODE_ENQUEUE, 8'h00, 8'hFF));
      send(make_item(sms_pkg::MODE_ENQUEUE, 8'hA5, 8'h5A));
      send(make_item(sms_pkg::MODE_ENQUEUE, 8'h5A, 8'hA5));
      send(make_item(sms_pkg::MODE_ENQUEUE, 8'h01, 8'h80));
      send(make_item(sms_pkg::MODE_ENQUEUE, 8'h80, 8'h01));
      send(make_item(sms_pkg::MODE_ENQUEUE, 8'h3C, 8'hC3));
      send(make_item(sms_pkg::MODE_ENQUEUE, 8'hFF, 8'hFF));
      // buffer full
      send(make_item(sms_pkg::MODE_ENQUEUE, 8'hFF, 8'hFF));
      send(make_item(sms_pkg::MODE_ENQUEUE, 8'h00, 8'h00));
      repeat (12) send(make_item(sms_pkg::MODE_TICK, 8'hFF, 8'hFF));

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain();
            write_reg(sms_pkg::CSR_MESSAGES_PER_SYNC, phase_msgs[p]);
            write_reg(sms_pkg::CSR_SYNC_GAP_TICKS, phase_gap[p]);
         end
         no_idle = phase_quiet[p];
         for (int n = 0; n < phase_items[p]; n++) begin
            send(make_item($urandom_range(99) < phase_tick[p] ? sms_pkg::MODE_TICK
                                                              : sms_pkg::MODE_ENQUEUE,
                           8'($urandom_range(255)), 8'($urandom_range(255))));
            pace();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d enqueues (%0d refused on a full buffer) and %0d ticks (%0d in sync gaps)",
               enqueues, refusals, ticks, gap_ticks);
      $display("across %0d register settings, including zero and full-scale values", PHASES);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
